FILE: rtl/kbad_pkg.sv
// ----------------------------------------------------------------------------
// kbad_pkg
// Shared types and constants for the Kahan box-average downsampler.
// ----------------------------------------------------------------------------
package kbad_pkg;

    localparam int          COUNT_WIDTH_DEF = 16;
    localparam int          BOX_W           = 16;
    localparam logic [15:0] BOX_SIZE_RST    = 16'd1;

    localparam logic [10:0] EXP_INF      = 11'h7FF;
    localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    // input item kinds (tuser)
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_DIV = 2'd2
    } t_fop;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

endpackage

FILE: rtl/kbad_fpu.sv
// ----------------------------------------------------------------------------
// kbad_fpu
// Shared double-precision unit: add/subtract in four steps, division of a
// double by an unsigned count one quotient bit per cycle, common normalise
// and round-to-nearest-even.
// ----------------------------------------------------------------------------
module kbad_fpu
    import kbad_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_fpu_req               i_req,
    input  logic [63:0]            i_a,
    input  logic [63:0]            i_b,
    input  logic [COUNT_WIDTH-1:0] i_n,
    output logic                   o_done,
    output logic [63:0]            o_result
);

    localparam int K   = COUNT_WIDTH + 3;
    localparam int QW  = 53 + K;
    localparam int MW  = QW + 3;
    localparam int LZW = $clog2(MW);
    localparam int DCW = $clog2(QW);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_ADD  = 5'b00010,
        F_DIV  = 5'b00100,
        F_NORM = 5'b01000,
        F_RND  = 5'b10000
    } t_fstate;

    function automatic logic [LZW-1:0] clz(input logic [MW-2:0] v);
        logic [LZW-1:0] z;
        z = LZW'(MW - 1);
        for (int i = 0; i < MW - 1; i++) begin
            if (v[i]) begin
                z = LZW'(MW - 2 - i);
            end
        end
        return z;
    endfunction

    t_fstate          r_state, n_state;
    logic             r_done, n_done;
    logic [63:0]      r_result, n_result;
    logic [55:0]      r_big, n_big, r_small, n_small;
    logic [MW-1:0]    r_man, n_man;
    logic [11:0]      r_e, n_e;
    logic             r_sign, n_sign, r_zsign, n_zsign, r_effsub, n_effsub;
    logic             r_st, n_st;
    logic             r_spec, n_spec;
    logic [63:0]      r_spec_val, n_spec_val;
    logic [QW-1:0]    r_num, n_num;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem, r_n, n_n;
    logic [DCW-1:0]   r_dcnt, n_dcnt;

    // operand unpack
    logic        sa, sb;
    logic [10:0] ea, eb, ea_e, eb_e, e_big, e_small, diff;
    logic [51:0] fa, fb;
    logic [52:0] ma, mb, m_small;
    logic        a_nan, b_nan, a_inf, b_inf, b_gt, far;
    logic [55:0] small56, shifted;
    logic        lost;
    logic [56:0] sum57;
    logic [COUNT_WIDTH:0]   trial;
    logic                   qbit;
    logic [COUNT_WIDTH-1:0] rem_nx;
    logic [QW-1:0]          num_nx;
    logic [LZW-1:0] lz;
    logic [11:0]    lz_e, lim, sh;
    logic [51:0]    frac;
    logic           grd, stk, inc;
    logic [62:0]    mag;

    always_comb begin
        sa    = i_a[63];
        ea    = i_a[62:52];
        fa    = i_a[51:0];
        sb    = i_b[63] ^ (i_req.op == FOP_SUB);
        eb    = i_b[62:52];
        fb    = i_b[51:0];
        a_nan = (ea == EXP_INF) && (fa != '0);
        b_nan = (eb == EXP_INF) && (fb != '0);
        a_inf = (ea == EXP_INF) && (fa == '0);
        b_inf = (eb == EXP_INF) && (fb == '0);
        ma    = {ea != '0, fa};
        mb    = {eb != '0, fb};
        ea_e  = (ea == '0) ? 11'd1 : ea;
        eb_e  = (eb == '0) ? 11'd1 : eb;
        b_gt  = {eb_e, mb} > {ea_e, ma};
        e_big   = b_gt ? eb_e : ea_e;
        e_small = b_gt ? ea_e : eb_e;
        m_small = b_gt ? ma : mb;
        diff    = e_big - e_small;
        far     = diff >= 11'd56;
        small56 = {m_small, 3'b000};
        shifted = far ? '0 : (small56 >> diff[5:0]);
        lost    = far ? (|small56) : (|(small56 & ~({56{1'b1}} << diff[5:0])));

        sum57 = r_effsub ? ({1'b0, r_big} - {1'b0, r_small})
                         : ({1'b0, r_big} + {1'b0, r_small});

        trial  = {r_rem, r_num[QW-1]};
        qbit   = trial >= {1'b0, r_n};
        rem_nx = qbit ? COUNT_WIDTH'(trial - {1'b0, r_n}) : trial[COUNT_WIDTH-1:0];
        num_nx = {r_num[QW-2:0], qbit};

        lz   = clz(r_man[MW-2:0]);
        lz_e = 12'(lz);
        lim  = r_e - 12'd1;
        sh   = (lz_e < lim) ? lz_e : lim;

        frac = r_man[MW-3:MW-54];
        grd  = r_man[MW-55];
        stk  = (|r_man[MW-56:0]) | r_st;
        inc  = grd & (stk | frac[0]);
        mag  = {(r_man[MW-2] ? r_e[10:0] : 11'd0), frac} + 63'(inc);
        if (r_e >= 12'd2047) begin
            mag = {EXP_INF, 52'd0};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_result   = r_result;
        n_big      = r_big;
        n_small    = r_small;
        n_man      = r_man;
        n_e        = r_e;
        n_sign     = r_sign;
        n_zsign    = r_zsign;
        n_effsub   = r_effsub;
        n_st       = r_st;
        n_spec     = r_spec;
        n_spec_val = r_spec_val;
        n_num      = r_num;
        n_rem      = r_rem;
        n_n        = r_n;
        n_dcnt     = r_dcnt;
        unique case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == FOP_DIV) begin
                        n_num      = {ma, {K{1'b0}}};
                        n_rem      = '0;
                        n_n        = i_n;
                        n_dcnt     = DCW'(QW - 1);
                        n_e        = {1'b0, ea_e};
                        n_sign     = sa;
                        n_spec     = a_nan | a_inf;
                        n_spec_val = a_nan ? (i_a | QUIET_BIT) : i_a;
                        n_state    = F_DIV;
                    end else begin
                        n_big    = {(b_gt ? mb : ma), 3'b000};
                        n_small  = {shifted[55:1], shifted[0] | lost};
                        n_e      = {1'b0, e_big};
                        n_sign   = b_gt ? sb : sa;
                        n_effsub = sa ^ sb;
                        n_zsign  = sa & sb;
                        n_spec   = a_nan | b_nan | a_inf | b_inf;
                        if (a_nan) begin
                            n_spec_val = i_a | QUIET_BIT;
                        end else if (b_nan) begin
                            n_spec_val = i_b | QUIET_BIT;
                        end else if (a_inf && b_inf && (sa != sb)) begin
                            n_spec_val = QNAN_DEFAULT;
                        end else if (a_inf) begin
                            n_spec_val = i_a;
                        end else begin
                            n_spec_val = {sb, i_b[62:0]};
                        end
                        n_state = F_ADD;
                    end
                end
            end
            F_ADD: begin
                n_man   = {sum57, {(MW-57){1'b0}}};
                n_st    = 1'b0;
                n_sign  = (sum57 == '0) ? r_zsign : r_sign;
                n_state = F_NORM;
            end
            F_DIV: begin
                n_num = num_nx;
                n_rem = rem_nx;
                if (r_dcnt == '0) begin
                    n_man   = {1'b0, num_nx, 2'b00};
                    n_st    = rem_nx != '0;
                    n_state = F_NORM;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                end
            end
            F_NORM: begin
                if (r_man[MW-1]) begin
                    n_man = r_man >> 1;
                    n_st  = r_st | r_man[0];
                    n_e   = r_e + 12'd1;
                end else begin
                    n_man = r_man << sh;
                    n_e   = r_e - sh;
                end
                n_state = F_RND;
            end
            F_RND: begin
                n_result = r_spec ? r_spec_val : {r_sign, mag};
                n_done   = 1'b1;
                n_state  = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_result   <= n_result;
        r_big      <= n_big;
        r_small    <= n_small;
        r_man      <= n_man;
        r_e        <= n_e;
        r_sign     <= n_sign;
        r_zsign    <= n_zsign;
        r_effsub   <= n_effsub;
        r_st       <= n_st;
        r_spec     <= n_spec;
        r_spec_val <= n_spec_val;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_n        <= n_n;
        r_dcnt     <= n_dcnt;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == F_IDLE)
        else $error("fpu started while busy");

    a_done_after_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == F_RND |=> r_done && r_state == F_IDLE)
        else $error("fpu round step did not complete");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV && r_dcnt != '0) |=> r_state == F_DIV)
        else $error("divide left early");

endmodule

FILE: rtl/kahan_box_average_downsampler_unit.sv
// ----------------------------------------------------------------------------
// kahan_box_average_downsampler_unit
// Box-average downsampler of doubles with Kahan compensated summation.
// ----------------------------------------------------------------------------
// channel   | handshake                    | payload
// s_axis    | s_axis_tvalid/s_axis_tready  | tdata = sample, tuser = op
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata = average, tuser = partial
// cfg       | i_cfg_valid/o_cfg_ready      | i_cfg_data = box_size
//
// A sample item makes four dependent add/subtract passes through the
// shared unit. Closing a box adds the bit-serial divide and the output
// load; a flush of a nonempty box does the same. Reset is synchronous,
// active low. The next item is taken while a result waits on m_axis; a
// further result waits for the output register to empty.
// ----------------------------------------------------------------------------
module kahan_box_average_downsampler_unit
    import kbad_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // [63:0] sample
    input  logic             s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] average
    output logic             m_axis_tuser,   // [0] partial
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [BOX_W-1:0] i_cfg_data
);

    localparam int SW = (COUNT_WIDTH > BOX_W) ? COUNT_WIDTH : BOX_W;
    localparam logic [SW-1:0] CNT_MAX = SW'({COUNT_WIDTH{1'b1}});

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_Y    = 7'b0000010,
        S_T    = 7'b0000100,
        S_D    = 7'b0001000,
        S_C    = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [BOX_W-1:0]       r_box;
    logic [63:0]            r_sum, n_sum, r_comp, n_comp, r_y, n_y, r_t, n_t;
    logic [63:0]            r_avg, n_avg;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_partial, n_partial;
    logic                   r_out_valid, n_out_valid;
    logic [63:0]            r_out_data, n_out_data;
    logic                   r_out_partial, n_out_partial;

    t_fpu_req               fpu_req;
    logic [63:0]            fpu_a, fpu_b, fpu_res;
    logic [COUNT_WIDTH-1:0] fpu_n;
    logic                   fpu_done;

    logic                   in_acc;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [SW-1:0]          box_ext, eff_size;
    logic                   box_full;

    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = r_state == S_IDLE;
    assign o_cfg_ready   = 1'b1;
    assign cnt_inc       = r_cnt + 1'b1;

    always_comb begin
        box_ext  = SW'(r_box);
        eff_size = box_ext;
        if (box_ext == '0) begin
            eff_size = SW'(1);
        end
        if (box_ext > CNT_MAX) begin
            eff_size = CNT_MAX;
        end
        box_full = SW'(cnt_inc) >= eff_size;
    end

    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = FOP_ADD;
        fpu_a         = r_sum;
        fpu_b         = r_comp;
        fpu_n         = r_cnt;
        n_state       = r_state;
        n_sum         = r_sum;
        n_comp        = r_comp;
        n_y           = r_y;
        n_t           = r_t;
        n_avg         = r_avg;
        n_cnt         = r_cnt;
        n_partial     = r_partial;
        n_out_valid   = r_out_valid & ~m_axis_tready;
        n_out_data    = r_out_data;
        n_out_partial = r_out_partial;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == OP_SAMPLE) begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = FOP_SUB;
                        fpu_a         = s_axis_tdata;
                        fpu_b         = r_comp;
                        n_state       = S_Y;
                    end else if (r_cnt != '0) begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = FOP_DIV;
                        n_partial     = 1'b1;
                        n_state       = S_DIV;
                    end
                end
            end
            S_Y: begin
                if (fpu_done) begin
                    n_y           = fpu_res;
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FOP_ADD;
                    fpu_a         = r_sum;
                    fpu_b         = fpu_res;
                    n_state       = S_T;
                end
            end
            S_T: begin
                if (fpu_done) begin
                    n_t           = fpu_res;
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FOP_SUB;
                    fpu_a         = fpu_res;
                    fpu_b         = r_sum;
                    n_state       = S_D;
                end
            end
            S_D: begin
                if (fpu_done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FOP_SUB;
                    fpu_a         = fpu_res;
                    fpu_b         = r_y;
                    n_state       = S_C;
                end
            end
            S_C: begin
                if (fpu_done) begin
                    n_comp = fpu_res;
                    n_sum  = r_t;
                    n_cnt  = cnt_inc;
                    if (box_full) begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = FOP_DIV;
                        fpu_a         = r_t;
                        fpu_n         = cnt_inc;
                        n_partial     = 1'b0;
                        n_state       = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (fpu_done) begin
                    n_avg   = fpu_res;
                    n_sum   = '0;
                    n_comp  = '0;
                    n_cnt   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_data    = r_avg;
                    n_out_partial = r_partial;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box       <= BOX_SIZE_RST;
            r_sum       <= '0;
            r_comp      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_comp      <= n_comp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_box <= i_cfg_data;
            end
        end
        r_y           <= n_y;
        r_t           <= n_t;
        r_avg         <= n_avg;
        r_partial     <= n_partial;
        r_out_data    <= n_out_data;
        r_out_partial <= n_out_partial;
    end

    kbad_fpu #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fpu_req),
        .i_a      (fpu_a),
        .i_b      (fpu_b),
        .i_n      (fpu_n),
        .o_done   (fpu_done),
        .o_result (fpu_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_partial;

    a_out_clears_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_cnt == '0)
        else $error("box not cleared after average");

    a_empty_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == OP_FLUSH && r_cnt == '0) |=> r_state == S_IDLE)
        else $error("flush of empty box started work");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_done |-> (r_state == S_Y || r_state == S_T || r_state == S_D
                      || r_state == S_C || r_state == S_DIV))
        else $error("unit result with no step waiting");

endmodule

FILE: sim/kahan_box_average_downsampler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kahan_box_average_downsampler_unit_tb
// Self-checking bench: directed and random double samples and flushes over
// several box sizes, predicted with compensated summation on reals and
// compared item by item against m_axis, under random stalls on both sides.
// ----------------------------------------------------------------------------
module kahan_box_average_downsampler_unit_tb;
    import kbad_pkg::*;

    localparam int          CW        = COUNT_WIDTH_DEF;
    localparam int          DRAIN_CYC = CW + 200;
    localparam int unsigned CYC_LIMIT = 4000000;

    typedef struct packed {
        logic        op;
        logic [63:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [63:0] average;
        logic        partial;
    } t_avg_item;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata;   // [63:0] sample
    logic             s_axis_tuser;   // [0] op
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [63:0]      m_axis_tdata;   // [63:0] average
    logic             m_axis_tuser;   // [0] partial
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [BOX_W-1:0] i_cfg_data;

    t_in_item    pending_q[$];
    t_avg_item   avg_exp_q[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned err_cnt = 0;
    int unsigned cyc_cnt = 0;

    // averaging state of the box
    logic [15:0]   box_reg;
    real           box_sum;
    real           box_comp;
    logic [CW-1:0] box_cnt;

    kahan_box_average_downsampler_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [CW-1:0] eff_box_size();
        logic [CW:0] s;
        s = {{CW{1'b0}}, 1'b0} | box_reg;
        if (s == '0) s = (CW+1)'(1);
        if (s > {1'b0, {CW{1'b1}}}) s = {1'b0, {CW{1'b1}}};
        return s[CW-1:0];
    endfunction

    task automatic emit_box_average(input logic part);
        t_avg_item r;
        r.average = $realtobits(box_sum / real'(box_cnt));
        r.partial = part;
        avg_exp_q.push_back(r);
        box_sum  = 0.0;
        box_comp = 0.0;
        box_cnt  = '0;
    endtask

    task automatic predict_item(input t_in_item it);
        real y;
        real t;
        if (it.op == OP_FLUSH) begin
            if (box_cnt != 0) emit_box_average(1'b1);
        end else begin
            y        = $bitstoreal(it.sample) - box_comp;
            t        = box_sum + y;
            box_comp = (t - box_sum) - y;
            box_sum  = t;
            box_cnt  = box_cnt + 1'b1;
            if (box_cnt >= eff_box_size()) emit_box_average(1'b0);
        end
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {$urandom(), $urandom()};
            1: begin
                case ($urandom_range(0, 7))
                    0: v = 64'h0000_0000_0000_0000;
                    1: v = 64'h7FF0_0000_0000_0000;
                    2: v = 64'h7FF8_0000_0000_0000;
                    3: v = {12'h7FF, 20'h0, $urandom() | 32'h1};
                    4: v = 64'h7FEF_FFFF_FFFF_FFFF;
                    5: v = {12'h000, 20'($urandom_range(0, 20'hFFFFF)), $urandom()};
                    6: v = 64'h0010_0000_0000_0000;
                    default: v = 64'h3FF0_0000_0000_0000;
                endcase
                v[63] = 1'($urandom_range(0, 1));
            end
            2: v = {1'b0, 11'd1023 + 11'($urandom_range(0, 60)), 20'($urandom()),
                    $urandom()};
            default: v = {1'($urandom_range(0, 1)), 11'd1003 + 11'($urandom_range(0, 40)),
                          20'($urandom()), $urandom()};
        endcase
        return v;
    endfunction

    task automatic push_item(input logic op, input logic [63:0] smp);
        t_in_item it;
        it.op     = op;
        it.sample = smp;
        pending_q.push_back(it);
    endtask

    task automatic wait_results_done();
        while (pending_q.size() != 0 || s_axis_tvalid || avg_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_box_size(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        box_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [15:0] box, input int n, input int unsigned s_pct,
                                input int unsigned r_pct, input int flush_pct);
        write_box_size(box);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < flush_pct)
                push_item(OP_FLUSH, {$urandom(), $urandom()});
            else
                push_item(OP_SAMPLE, rand_double());
        end
        wait_results_done();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            logic free;
            free = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(pending_q.pop_front());
                free = 1'b1;
            end
            if (free) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_q[0].op;
                    s_axis_tdata  <= pending_q[0].sample;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_avg_item e;
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYC_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (avg_exp_q.size() == 0) begin
                $display("%0t unexpected average %h partial %b", $time, m_axis_tdata,
                         m_axis_tuser);
                err_cnt++;
            end else begin
                e = avg_exp_q.pop_front();
                if (m_axis_tdata !== e.average || m_axis_tuser !== e.partial) begin
                    $display("%0t mismatch: expected %h/%b actual %h/%b", $time, e.average,
                             e.partial, m_axis_tdata, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        box_reg       = BOX_SIZE_RST;
        box_sum       = 0.0;
        box_comp      = 0.0;
        box_cnt       = '0;
        i_rst_n       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset box size, specials, flushes
        push_item(OP_FLUSH,  64'h0);
        push_item(OP_SAMPLE, 64'h0000_0000_0000_0000);
        push_item(OP_SAMPLE, 64'h8000_0000_0000_0000);
        push_item(OP_SAMPLE, 64'h7FF0_0000_0000_0000);
        push_item(OP_SAMPLE, 64'hFFF0_0000_0000_0000);
        push_item(OP_SAMPLE, 64'h7FF4_0000_0000_0001);
        push_item(OP_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(OP_SAMPLE, 64'h0000_0000_0000_0001);
        push_item(OP_SAMPLE, 64'h7FEF_FFFF_FFFF_FFFF);
        wait_results_done();
        write_box_size(16'd3);
        push_item(OP_SAMPLE, 64'h7FEF_FFFF_FFFF_FFFF);
        push_item(OP_SAMPLE, 64'h7FEF_FFFF_FFFF_FFFF);
        push_item(OP_SAMPLE, 64'hFFEF_FFFF_FFFF_FFFF);
        push_item(OP_SAMPLE, 64'h3FF0_0000_0000_0000);
        push_item(OP_SAMPLE, 64'h3CA0_0000_0000_0000);
        push_item(OP_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF);
        push_item(OP_FLUSH,  64'h0);
        push_item(OP_SAMPLE, 64'h7FF0_0000_0000_0000);
        push_item(OP_SAMPLE, 64'hFFF0_0000_0000_0000);
        push_item(OP_SAMPLE, 64'h0000_0000_0000_0001);
        wait_results_done();
        // zero box size acts as one
        write_box_size(16'd0);
        push_item(OP_SAMPLE, 64'h4000_0000_0000_0000);
        push_item(OP_FLUSH,  64'h0);
        wait_results_done();
        // largest box, closed by flush
        write_box_size(16'hFFFF);
        for (int i = 0; i < 20; i++) push_item(OP_SAMPLE, rand_double());
        push_item(OP_FLUSH, 64'h0);
        wait_results_done();

        random_phase(16'd4,  200, 0,  0,  5);
        // sender never idles, then the bench waits until all averages are out
        send_idle_pct = 0;
        for (int i = 0; i < 7; i++) push_item(OP_SAMPLE, rand_double());
        wait_results_done();
        random_phase(16'd1,  200, 68, 0,  3);
        random_phase(16'd7,  200, 0,  68, 5);
        // box lowered mid-box: leave 5 samples open, then size 2
        random_phase(16'd8,  5,   0,  0,  0);
        random_phase(16'd2,  200, 19, 19, 5);
        random_phase(16'd0,  150, 68, 68, 10);
        random_phase(16'd3,  200, 0,  0,  8);
        random_phase(16'hFFFF, 40, 19, 19, 0);
        random_phase(16'd5,  60,  0,  0,  5);
        push_item(OP_FLUSH, 64'h0);
        wait_results_done();

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
